// ===== hdl/abe_pkg.sv =====
// abe_pkg: types, codes and constants shared by the bandwidth estimator modules.
// No dependencies.
package abe_pkg;

   localparam int DataWidth   = 32;
   localparam int CfgWidth    = 16;
   localparam int FuncWidth   = 2;
   localparam int CsrIdxWidth = 1;

   localparam logic [CfgWidth-1:0] MssReset       = 16'd1460;
   localparam logic [CfgWidth-1:0] MinWindowReset = 16'd50;

   localparam int FilterWeight = 7;
   localparam int FilterShift  = 3;

   // event codes
   localparam logic [FuncWidth-1:0] FUNC_RTT  = 2'd0;
   localparam logic [FuncWidth-1:0] FUNC_FAST = 2'd1;
   localparam logic [FuncWidth-1:0] FUNC_SLOW = 2'd2;
   localparam logic [FuncWidth-1:0] FUNC_INIT = 2'd3;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_MSS        = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MIN_WINDOW = 1'd1;

   typedef struct packed {
      logic [FuncWidth-1:0] func;
      logic [DataWidth-1:0] now_ticks;
      logic [DataWidth-1:0] ack_una;
      logic [DataWidth-1:0] rtt_ticks;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] bw_smoothed;
      logic [DataWidth-1:0] bw_raw;
      logic                 window_closed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic cred;
      logic apply;
      logic filt1;
      logic filt2;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FuncWidth-1:0] func;
      logic                 closed;
      logic                 div_busy;
   } status_type;

   // (7*old + sample) >> 3, wrapping at 32 bits
   function automatic logic [DataWidth-1:0] smooth(input logic [DataWidth-1:0] old,
                                                    input logic [DataWidth-1:0] sample);
      logic [DataWidth-1:0] weighted;
      logic [DataWidth-1:0] total;
      weighted = DataWidth'(old * DataWidth'(FilterWeight));
      total    = weighted + sample;
      return total >> FilterShift;
   endfunction

endpackage

// ===== hdl/abe_div.sv =====
// abe_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on abe_pkg.
module abe_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [abe_pkg::DataWidth-1:0]  dividend,
   input  logic [abe_pkg::DataWidth-1:0]  divisor,
   output logic                           busy,
   output logic [abe_pkg::DataWidth-1:0]  quotient
);

   localparam int W      = abe_pkg::DataWidth;
   localparam int CountW = $clog2(W + 1);

   logic [CountW-1:0] count_ff, count_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      quo_ff, quo_in;
   logic [W-1:0]      div_ff, div_in;
   logic [W:0]        trial;

   always_comb begin
      trial    = {rem_ff, quo_ff[W-1]} - {1'b0, div_ff};
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         count_in = CountW'(W);
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== hdl/abe_datapath.sv =====
// abe_datapath: estimator state, configuration registers, window arithmetic,
// filters and result register. Depends on abe_pkg and abe_div.
module abe_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  abe_pkg::req_type                  req_data,
   output abe_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [abe_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [abe_pkg::CfgWidth-1:0]      csr_wdata,
   input  abe_pkg::cmd_type                  cmd,
   output abe_pkg::status_type               status
);

   localparam int W = abe_pkg::DataWidth;

   logic [abe_pkg::CfgWidth-1:0] mss_ff, min_window_ff;

   logic [W-1:0] est_first_ff, est_second_ff, window_begin_ff, bytes_ff;
   logic [W-1:0] last_una_ff, credited_ff, last_rtt_ff;
   logic         awaiting_ff, closed_ff, seed_ff;

   abe_pkg::req_type item_ff;
   logic [W-1:0]     elapsed_ff, bound_ff, delta_ff, d_ff;
   abe_pkg::rsp_type rsp_ff;

   logic [W-1:0] mss_w, min_window_w, una_base;
   logic         is_ack, is_slow, close_now, dup;
   logic [W-1:0] cred_minus_d, d_minus_cred;
   logic         cred_covers;
   logic         div_busy;
   logic [W-1:0] quotient;

   assign mss_w        = W'(mss_ff);
   assign min_window_w = W'(min_window_ff);
   assign una_base     = awaiting_ff ? req_data.ack_una : last_una_ff;

   assign is_slow   = (item_ff.func == abe_pkg::FUNC_SLOW);
   assign is_ack    = (item_ff.func == abe_pkg::FUNC_FAST) || is_slow;
   assign close_now = (last_rtt_ff != '0) && (elapsed_ff > bound_ff);
   assign dup       = (delta_ff == '0);

   assign cred_minus_d = credited_ff - d_ff;
   assign d_minus_cred = d_ff - credited_ff;
   assign cred_covers  = (credited_ff >= d_ff);

   abe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && is_ack && close_now),
      .dividend (bytes_ff),
      .divisor  (elapsed_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff        <= abe_pkg::MssReset;
         min_window_ff <= abe_pkg::MinWindowReset;
      end else if (csr_wr_en) begin
         if (csr_index == abe_pkg::CSR_MSS) begin
            mss_ff <= csr_wdata;
         end else if (csr_index == abe_pkg::CSR_MIN_WINDOW) begin
            min_window_ff <= csr_wdata;
         end
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff    <= req_data;
         elapsed_ff <= req_data.now_ticks - window_begin_ff;
         bound_ff   <= (last_rtt_ff > min_window_w) ? last_rtt_ff : min_window_w;
         delta_ff   <= req_data.ack_una - una_base;
      end
      if (cmd.load_rsp) begin
         rsp_ff.bw_smoothed   <= est_second_ff;
         rsp_ff.bw_raw        <= est_first_ff;
         rsp_ff.window_closed <= closed_ff;
      end
   end

   // estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         est_first_ff    <= '0;
         est_second_ff   <= '0;
         window_begin_ff <= '0;
         bytes_ff        <= '0;
         last_una_ff     <= '0;
         credited_ff     <= '0;
         last_rtt_ff     <= '0;
         awaiting_ff     <= 1'b1;
         closed_ff       <= 1'b0;
         seed_ff         <= 1'b0;
         d_ff            <= '0;
      end else begin
         if (cmd.eval) begin
            closed_ff <= 1'b0;
            case (item_ff.func)
               abe_pkg::FUNC_RTT: begin
                  last_rtt_ff <= item_ff.rtt_ticks;
               end
               abe_pkg::FUNC_INIT: begin
                  est_first_ff    <= '0;
                  est_second_ff   <= '0;
                  bytes_ff        <= '0;
                  credited_ff     <= '0;
                  last_rtt_ff     <= '0;
                  window_begin_ff <= item_ff.now_ticks;
                  last_una_ff     <= item_ff.ack_una;
                  awaiting_ff     <= 1'b1;
               end
               default: begin
                  closed_ff   <= close_now;
                  awaiting_ff <= 1'b0;
                  last_una_ff <= item_ff.ack_una;
                  if (close_now) begin
                     bytes_ff        <= '0;
                     window_begin_ff <= item_ff.now_ticks;
                  end
                  // a slow duplicate ack is credited one segment
                  if (is_slow && dup) begin
                     d_ff        <= mss_w;
                     credited_ff <= credited_ff + mss_w;
                  end else begin
                     d_ff <= delta_ff;
                  end
               end
            endcase
         end
         // settle partial or delayed acks against the credit
         if (cmd.cred && is_slow && (d_ff > mss_w)) begin
            if (cred_covers) begin
               credited_ff <= cred_minus_d;
               d_ff        <= mss_w;
            end else begin
               d_ff        <= d_minus_cred;
               credited_ff <= '0;
            end
         end
         if (cmd.apply) begin
            bytes_ff <= bytes_ff + d_ff;
         end
         if (cmd.filt1) begin
            seed_ff <= (est_first_ff == '0) && (est_second_ff == '0);
            if ((est_first_ff == '0) && (est_second_ff == '0)) begin
               est_first_ff  <= quotient;
               est_second_ff <= quotient;
            end else begin
               est_first_ff <= abe_pkg::smooth(est_first_ff, quotient);
            end
         end
         if (cmd.filt2 && !seed_ff) begin
            est_second_ff <= abe_pkg::smooth(est_second_ff, est_first_ff);
         end
      end
   end

   assign rsp_data        = rsp_ff;
   assign status.func     = item_ff.func;
   assign status.closed   = closed_ff;
   assign status.div_busy = div_busy;

endmodule

// ===== hdl/abe_ctrl.sv =====
// abe_ctrl: sequencer for one event at a time and the result valid flag.
// Depends on abe_pkg.
module abe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  abe_pkg::status_type  status,
   output abe_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_CRED,
      S_APPLY,
      S_DIV,
      S_FILT1,
      S_FILT2,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if ((status.func == abe_pkg::FUNC_FAST) || (status.func == abe_pkg::FUNC_SLOW)) begin
               state_in = S_CRED;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CRED: begin
            cmd.cred = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.closed ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_FILT1;
            end
         end
         S_FILT1: begin
            cmd.filt1 = 1'b1;
            state_in  = S_FILT2;
         end
         S_FILT2: begin
            cmd.filt2 = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ack_bandwidth_estimator.sv =====
// ack_bandwidth_estimator: top level of the ack-driven bandwidth estimator.
// Depends on abe_pkg, abe_ctrl and abe_datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  abe_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  abe_pkg::rsp_type
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// From accept to rsp_valid, an rtt sample or flow init takes the eval and done steps;
// an ack adds credit and apply; one that closes the window adds the serial divider
// (one quotient bit per cycle), filt1 and filt2. One event is in flight at a time;
// the next is accepted while the result still waits in the output register.
// Reset is synchronous and restores register defaults and estimator state.
// A stalled result holds the sequencer in its last step.
module ack_bandwidth_estimator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  abe_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output abe_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [abe_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [abe_pkg::CfgWidth-1:0]     csr_wdata
);

   abe_pkg::cmd_type    cmd;
   abe_pkg::status_type status;

   abe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== hdl/abe_checker.sv =====
// abe_checker: port-level assertions for ack_bandwidth_estimator, and its bind.
// Depends on abe_pkg.
module abe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input abe_pkg::rsp_type  rsp_data
);

   // one event at a time: an accepted beat stalls the input next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepted beat");

   // no result can come out the cycle after an accept with an empty output
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind ack_bandwidth_estimator abe_checker u_abe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
